// File: rtl/u2af_pkg.sv
// ----------------------------------------------------------------------------
// u2af_pkg
// Shared types, character codes and the code point fold for the UTF-8 to
// ASCII folding block.
// ----------------------------------------------------------------------------
package u2af_pkg;

    localparam int CodeW   = 21;
    localparam int MaxOut  = 4;
    localparam int CountW  = 3;

    localparam logic [7:0] CharApos  = 8'h27;
    localparam logic [7:0] CharQuote = 8'h22;
    localparam logic [7:0] CharDash  = 8'h2D;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharDot   = 8'h2E;
    localparam logic [7:0] CharQmark = 8'h3F;

    typedef logic [CodeW-1:0] t_code;

    // decoder state: gathered code point bits and continuations still due
    typedef struct packed {
        t_code       acc;
        logic [1:0]  rem;
    } t_dec_state;

    // one fold gives a run of cnt copies of ch (0, 1 or 3)
    typedef struct packed {
        logic [1:0]  cnt;
        logic [7:0]  ch;
    } t_fold;

    // all result words of one input word, oldest in entry 0
    typedef struct packed {
        logic [MaxOut-1:0][7:0] bytes;
        logic [CountW-1:0]      cnt;
    } t_pack;

    function automatic t_fold fold_code(input t_code c);
        t_fold f;
        f.cnt = 2'd1;
        f.ch  = CharQmark;
        case (c)
            21'h002018, 21'h002019, 21'h00201A, 21'h002032: begin
                f.ch = CharApos;
            end
            21'h00201C, 21'h00201D, 21'h00201E, 21'h002033: begin
                f.ch = CharQuote;
            end
            21'h002013, 21'h002014, 21'h002212: begin
                f.ch = CharDash;
            end
            21'h0000A0: begin
                f.ch = CharSpace;
            end
            21'h002026: begin
                f.cnt = 2'd3;
                f.ch  = CharDot;
            end
            21'h00FEFF: begin
                f.cnt = 2'd0;
            end
            default: begin
                f.ch = CharQmark;
            end
        endcase
        return f;
    endfunction

endpackage

// File: rtl/u2af_in_if.sv
// ----------------------------------------------------------------------------
// u2af_in_if
// Text byte channel: valid/ready handshake with byte and end-of-text flag.
// ----------------------------------------------------------------------------
interface u2af_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

// File: rtl/u2af_out_if.sv
// ----------------------------------------------------------------------------
// u2af_out_if
// Folded ASCII channel: valid/ready handshake with byte and last-of-run flag.
// ----------------------------------------------------------------------------
interface u2af_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ascii_byte;
    logic       run_last;

    modport source (output valid, output ascii_byte, output run_last, input ready);
    modport sink   (input valid, input ascii_byte, input run_last, output ready);
endinterface

// File: rtl/u2af_decode.sv
// ----------------------------------------------------------------------------
// u2af_decode
// Single-pass UTF-8 step: next decoder state and the packed result words for
// one input byte.
// ----------------------------------------------------------------------------
module u2af_decode (
    input  u2af_pkg::t_dec_state i_state,
    input  logic [7:0]           i_byte,
    input  logic                 i_end,
    output u2af_pkg::t_dec_state o_state,
    output u2af_pkg::t_pack      o_pack
);

    u2af_pkg::t_fold      seg_a;
    u2af_pkg::t_fold      seg_c;
    logic                 seg_b_cnt;
    logic [7:0]           seg_b_ch;
    u2af_pkg::t_dec_state nxt;
    u2af_pkg::t_code      acc_cont;
    logic                 taken;
    logic [u2af_pkg::CountW-1:0] len_a;
    logic [u2af_pkg::CountW-1:0] len_ab;
    logic [u2af_pkg::CountW-1:0] len_all;

    assign acc_cont = {i_state.acc[u2af_pkg::CodeW-7:0], i_byte[5:0]};

    always_comb begin
        seg_a     = '0;
        seg_c     = '0;
        seg_b_cnt = 1'b0;
        seg_b_ch  = 8'h00;
        nxt       = i_state;
        taken     = 1'b0;

        if (i_state.rem != 2'd0) begin
            if (i_byte[7:6] == 2'b10) begin
                nxt.acc = acc_cont;
                nxt.rem = i_state.rem - 2'd1;
                if (nxt.rem == 2'd0) begin
                    seg_a   = u2af_pkg::fold_code(acc_cont);
                    nxt.acc = '0;
                end
                taken = 1'b1;
            end else begin
                // sequence cut short: fold what has been gathered
                seg_a = u2af_pkg::fold_code(i_state.acc);
                nxt   = '0;
            end
        end

        if (!taken) begin
            if (!i_byte[7]) begin
                seg_b_cnt = 1'b1;
                seg_b_ch  = i_byte;
            end else if (i_byte[7:5] == 3'b110) begin
                nxt.acc = {16'h0000, i_byte[4:0]};
                nxt.rem = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                nxt.acc = {17'h00000, i_byte[3:0]};
                nxt.rem = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                nxt.acc = {18'h00000, i_byte[2:0]};
                nxt.rem = 2'd3;
            end else begin
                seg_b_cnt = 1'b1;
                seg_b_ch  = u2af_pkg::CharQmark;
            end
        end

        // end of text: flush whatever is still pending
        if (i_end && nxt.rem != 2'd0) begin
            seg_c = u2af_pkg::fold_code(nxt.acc);
            nxt   = '0;
        end
    end

    assign len_a   = {1'b0, seg_a.cnt};
    assign len_ab  = len_a + {2'b00, seg_b_cnt};
    assign len_all = len_ab + {1'b0, seg_c.cnt};

    always_comb begin
        for (int k = 0; k < u2af_pkg::MaxOut; k++) begin
            if (u2af_pkg::CountW'(k) < len_a) begin
                o_pack.bytes[k] = seg_a.ch;
            end else if (u2af_pkg::CountW'(k) < len_ab) begin
                o_pack.bytes[k] = seg_b_ch;
            end else begin
                o_pack.bytes[k] = seg_c.ch;
            end
        end
        // drop anything beyond the result capacity
        if (len_all > u2af_pkg::CountW'(u2af_pkg::MaxOut)) begin
            o_pack.cnt = u2af_pkg::CountW'(u2af_pkg::MaxOut);
        end else begin
            o_pack.cnt = len_all;
        end
    end

    assign o_state = nxt;

endmodule

// File: rtl/utf8_to_ascii_fold.sv
// ----------------------------------------------------------------------------
// utf8_to_ascii_fold
// Streaming UTF-8 to ASCII transliteration, one text byte per word.
// ----------------------------------------------------------------------------
// Input channel i_in carries one UTF-8 byte and an end-of-text flag per word;
// output channel o_out carries folded ASCII bytes, run_last marking the final
// byte caused by one input word. An input word may give no output at all
// (lead or continuation byte, byte order mark) or up to four bytes.
// The decode is one combinational pass from the decoder state register and
// the input word into a result register holding every byte of that word.
// Latency: the first result byte is valid the cycle after acceptance.
// Throughput: one input word per cycle while each gives at most one byte and
// the receiver is ready; a word giving more holds the result register until
// all are taken, as the output drains one byte per cycle while ready is high.
// Input ready is high when the result register is empty or its last byte is
// being taken in the same cycle, so a stalled receiver holds the input off
// once that last byte is not taken.
// Reset (synchronous, active low) clears the decoder state and empties the result
// register (its byte array is not reset); no sequence is pending afterwards.
// ----------------------------------------------------------------------------
module utf8_to_ascii_fold (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u2af_in_if.sink     i_in,
    u2af_out_if.source  o_out
);

    u2af_pkg::t_dec_state r_state;
    u2af_pkg::t_dec_state n_state;
    u2af_pkg::t_dec_state dec_state;
    u2af_pkg::t_pack      dec_pack;

    logic [u2af_pkg::CountW-1:0]        r_cnt;
    logic [u2af_pkg::CountW-1:0]        n_cnt;
    logic [u2af_pkg::MaxOut-1:0][7:0]   r_bytes;
    logic [u2af_pkg::MaxOut-1:0][7:0]   n_bytes;

    logic accept;
    logic pop;

    u2af_decode u_decode (
        .i_state (r_state),
        .i_byte  (i_in.text_byte),
        .i_end   (i_in.text_end),
        .o_state (dec_state),
        .o_pack  (dec_pack)
    );

    assign i_in.ready = (r_cnt == '0) ||
                        (r_cnt == u2af_pkg::CountW'(1) && o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.ascii_byte = r_bytes[0];
    assign o_out.run_last   = (r_cnt == u2af_pkg::CountW'(1));
    assign pop              = o_out.valid && o_out.ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bytes = r_bytes;
        if (accept) begin
            n_state = dec_state;
            n_cnt   = dec_pack.cnt;
            n_bytes = dec_pack.bytes;
        end else if (pop) begin
            // advance to the next byte of the run
            n_cnt   = r_cnt - u2af_pkg::CountW'(1);
            n_bytes = {8'h00, r_bytes[u2af_pkg::MaxOut-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= u2af_pkg::CountW'(u2af_pkg::MaxOut))
        else $error("result count beyond capacity");

    a_ready_only_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_cnt <= u2af_pkg::CountW'(1)))
        else $error("input taken while a run is still draining");

    a_pop_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_cnt > u2af_pkg::CountW'(1)) |=>
        (r_cnt == $past(r_cnt) - u2af_pkg::CountW'(1)))
        else $error("run did not advance on a taken byte");

    a_pending_on_accept_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.text_end) |=> (r_state.rem == 2'd0))
        else $error("sequence still pending after end of text");

endmodule
